@@ hdl/sscc_pkg.sv @@
// Shared types and constants for the set score scatter accumulator.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package sscc_pkg;

	// Request operation codes
	localparam logic [1:0] FUNC_LOAD = 2'd0;
	localparam logic [1:0] FUNC_ACC  = 2'd1;
	localparam logic [1:0] FUNC_READ = 2'd2;

	// Configuration register indexes
	localparam int         CFG_IW    = 2;
	localparam int         CFG_DW    = 13;
	localparam logic [CFG_IW-1:0] CFG_SETS  = 2'd0;
	localparam logic [CFG_IW-1:0] CFG_GENES = 2'd1;
	localparam logic [CFG_IW-1:0] CFG_COLS  = 2'd2;

	// Reset values of the registers
	localparam logic [10:0] SETS_RST  = 11'd1024;
	localparam logic [12:0] GENES_RST = 13'd4096;
	localparam logic [2:0]  COLS_RST  = 3'd1;

	// Command queue between front and back
	localparam int CMDQ_AW    = 1;
	localparam int CMDQ_DEPTH = 2 ** CMDQ_AW;

	typedef struct packed {
		logic [1:0]         func;
		logic [9:0]         set_index;
		logic [11:0]        gene_index;
		logic [1:0]         column;
		logic signed [31:0] score_value;
	} sscc_req_t;

	typedef struct packed {
		logic               status;
		logic signed [47:0] value;
	} sscc_rsp_t;

	typedef enum logic [1:0] {
		CMD_LOAD = 2'd0,
		CMD_ACC  = 2'd1,
		CMD_READ = 2'd2,
		CMD_FLAG = 2'd3
	} sscc_op_t;

	typedef struct packed {
		sscc_op_t    op;
		logic [9:0]  set_index;
		logic [11:0] gene_index;
		logic [1:0]  column;
		logic [31:0] score;
		logic [2:0]  ncols;
	} sscc_cmd_t;

endpackage

`default_nettype wire

@@ hdl/set_score_scatter_accumulator_core.sv @@
// Top level of the set score scatter accumulator.
// Depends on sscc_pkg, sscc_front, sscc_cmd_queue and sscc_back.
`default_nettype none

// Set score scatter accumulator. Keeps a Q16.16 score for every gene and
// column and a saturating Q32.16 sum for every set and column. Requests: load
// one score, accumulate one (set, gene) pair over every column in use, or read
// one sum; each request gives exactly one result, in order, with status set
// and nothing changed when an index is out of range. Requests are pushed into
// a queue-like port (push/full) and results are taken from one (empty/pop).
// The front checks ranges against the limits in force (register value capped
// at the build maximum) and queues a command; the back runs it. In the back a
// load or a flagged request is done in the idle state, a read passes the read
// state (registered memory read), and an accumulate does one column per cycle
// on the accumulator memory's single read and write port. The back starts a
// request once the result register is free. After reset the accumulator memory
// is cleared one entry a cycle, MAX_SETS * MAX_COLUMNS entries (4096 by
// default); full stays high throughout while configuration writes are taken.
// Configuration must only be written while the block is idle.

module set_score_scatter_accumulator_core import sscc_pkg::*; #(
	parameter int MAX_SETS    = 1024,
	parameter int MAX_GENES   = 4096,
	parameter int MAX_COLUMNS = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	output logic                   full,
	input  wire sscc_req_t         req,
	output logic                   empty,
	input  wire logic              pop,
	output sscc_rsp_t              result,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [CFG_IW-1:0] cfg_index,
	input  wire logic [CFG_DW-1:0] cfg_data
);

	sscc_cmd_t cmd_wr, cmd_rd;
	logic      cmd_push, cmd_pop, q_full, q_empty, clearing;

	// classification and limits
	sscc_front #(
		.MAX_SETS   (MAX_SETS),
		.MAX_GENES  (MAX_GENES),
		.MAX_COLUMNS(MAX_COLUMNS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.push     (push),
		.req      (req),
		.full     (full),
		.clearing (clearing),
		.q_full   (q_full),
		.cmd_push (cmd_push),
		.cmd      (cmd_wr)
	);

	// lets the front keep taking requests while the back is busy
	sscc_cmd_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (cmd_push),
		.wr    (cmd_wr),
		.full  (q_full),
		.pop   (cmd_pop),
		.rd    (cmd_rd),
		.empty (q_empty)
	);

	// memories, sequencer and result register
	sscc_back #(
		.MAX_SETS   (MAX_SETS),
		.MAX_GENES  (MAX_GENES),
		.MAX_COLUMNS(MAX_COLUMNS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_in   (cmd_rd),
		.cmd_empty(q_empty),
		.cmd_pop  (cmd_pop),
		.clearing (clearing),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

endmodule

`default_nettype wire

@@ hdl/sscc_front.sv @@
// Front end: configuration registers, range checks and request classification.
// Depends on sscc_pkg.
`default_nettype none

module sscc_front import sscc_pkg::*; #(
	parameter int MAX_SETS    = 1024,
	parameter int MAX_GENES   = 4096,
	parameter int MAX_COLUMNS = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [CFG_IW-1:0] cfg_index,
	input  wire logic [CFG_DW-1:0] cfg_data,
	input  wire logic              push,
	input  wire sscc_req_t         req,
	output logic                   full,
	input  wire logic              clearing,
	input  wire logic              q_full,
	output logic                   cmd_push,
	output sscc_cmd_t              cmd
);

	logic [10:0] sets_q;
	logic [12:0] genes_q;
	logic [2:0]  cols_q;

	logic [16:0] nsets, ngenes;
	logic [4:0]  ncols;
	logic        set_ok, gene_ok, col_ok;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sets_q  <= SETS_RST;
			genes_q <= GENES_RST;
			cols_q  <= COLS_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SETS:  sets_q  <= cfg_data[10:0];
				CFG_GENES: genes_q <= cfg_data[12:0];
				CFG_COLS:  cols_q  <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// limits in force: register value capped at the build maximum
	always_comb begin
		nsets  = ({6'd0, sets_q} < 17'(MAX_SETS)) ? {6'd0, sets_q} : 17'(MAX_SETS);
		ngenes = ({4'd0, genes_q} < 17'(MAX_GENES)) ? {4'd0, genes_q} : 17'(MAX_GENES);
		ncols  = ({2'd0, cols_q} < 5'(MAX_COLUMNS)) ? {2'd0, cols_q} : 5'(MAX_COLUMNS);
		set_ok  = {7'd0, req.set_index} < nsets;
		gene_ok = {5'd0, req.gene_index} < ngenes;
		col_ok  = {3'd0, req.column} < ncols;
	end

	always_comb begin
		cmd.set_index  = req.set_index;
		cmd.gene_index = req.gene_index;
		cmd.column     = req.column;
		cmd.score      = req.score_value;
		cmd.ncols      = ncols[2:0];
		unique case (req.func)
			FUNC_LOAD: cmd.op = (gene_ok && col_ok) ? CMD_LOAD : CMD_FLAG;
			FUNC_ACC:  cmd.op = (set_ok && gene_ok) ? CMD_ACC : CMD_FLAG;
			FUNC_READ: cmd.op = (set_ok && col_ok) ? CMD_READ : CMD_FLAG;
			default:   cmd.op = CMD_FLAG;
		endcase
	end

	assign full     = q_full | clearing;
	assign cmd_push = push & ~full;

endmodule

`default_nettype wire

@@ hdl/sscc_cmd_queue.sv @@
// Short command queue that decouples the front end from the back end.
// Depends on sscc_pkg.
`default_nettype none

module sscc_cmd_queue import sscc_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire sscc_cmd_t wr,
	output logic           full,
	input  wire logic      pop,
	output sscc_cmd_t      rd,
	output logic           empty
);

	sscc_cmd_t          slot_q [CMDQ_DEPTH];
	logic [CMDQ_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CMDQ_AW:0]   count_q;
	logic               do_push, do_pop;

	assign full    = count_q == (CMDQ_AW+1)'(CMDQ_DEPTH);
	assign empty   = count_q == '0;
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign rd      = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= wr;
	end

endmodule

`default_nettype wire

@@ hdl/sscc_back.sv @@
// Back end: score and accumulator memories, read-add-write sequencer, result register.
// Depends on sscc_pkg.
`default_nettype none

module sscc_back import sscc_pkg::*; #(
	parameter int MAX_SETS    = 1024,
	parameter int MAX_GENES   = 4096,
	parameter int MAX_COLUMNS = 4
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire sscc_cmd_t cmd_in,
	input  wire logic      cmd_empty,
	output logic           cmd_pop,
	output logic           clearing,
	output logic           empty,
	input  wire logic      pop,
	output sscc_rsp_t      result
);

	localparam int ACC_DEPTH = MAX_SETS * MAX_COLUMNS;
	localparam int SC_DEPTH  = MAX_GENES * MAX_COLUMNS;
	localparam int ACC_AW    = (ACC_DEPTH > 1) ? $clog2(ACC_DEPTH) : 1;
	localparam int SC_AW     = (SC_DEPTH > 1) ? $clog2(SC_DEPTH) : 1;

	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_READ  = 4'b0100,
		ST_ACC   = 4'b1000
	} state_t;

	logic [47:0] acc_mem [ACC_DEPTH];
	logic [31:0] sc_mem  [SC_DEPTH];

	state_t      state_q;
	sscc_cmd_t   cmd_q;
	logic [2:0]  col_q;
	logic [ACC_AW-1:0] clr_q;
	logic        out_valid_q;
	sscc_rsp_t   out_q;
	logic [47:0] acc_rdata_q;
	logic [31:0] sc_rdata_q;

	logic              acc_we, acc_re, sc_we, sc_re;
	logic [ACC_AW-1:0] acc_waddr, acc_raddr;
	logic [SC_AW-1:0]  sc_waddr, sc_raddr;
	logic [47:0]       acc_wdata;
	logic [48:0]       sum;
	logic [2:0]        col_nx;
	logic              last_col;

	function automatic logic [ACC_AW-1:0] acc_addr(logic [9:0] s, logic [2:0] c);
		logic [31:0] a;
		a = 32'(s) * 32'(MAX_COLUMNS) + 32'(c);
		return a[ACC_AW-1:0];
	endfunction

	function automatic logic [SC_AW-1:0] sc_addr(logic [11:0] g, logic [2:0] c);
		logic [31:0] a;
		a = 32'(g) * 32'(MAX_COLUMNS) + 32'(c);
		return a[SC_AW-1:0];
	endfunction

	assign clearing = state_q == ST_CLEAR;
	assign cmd_pop  = (state_q == ST_IDLE) && !cmd_empty && !out_valid_q;
	assign empty    = ~out_valid_q;
	assign result   = out_q;
	assign col_nx   = col_q + 3'd1;
	assign last_col = col_nx == cmd_q.ncols;

	// saturating 49-bit sum of element and sign-extended score
	always_comb begin
		sum = {acc_rdata_q[47], acc_rdata_q} + {{17{sc_rdata_q[31]}}, sc_rdata_q};
		if (sum[48] != sum[47])
			acc_wdata = sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
		else
			acc_wdata = sum[47:0];
	end

	always_comb begin
		acc_we    = 1'b0;
		acc_re    = 1'b0;
		sc_we     = 1'b0;
		sc_re     = 1'b0;
		acc_waddr = acc_addr(cmd_q.set_index, col_q);
		acc_raddr = acc_addr(cmd_in.set_index, {1'b0, cmd_in.column});
		sc_waddr  = sc_addr(cmd_in.gene_index, {1'b0, cmd_in.column});
		sc_raddr  = sc_addr(cmd_in.gene_index, 3'd0);
		unique case (state_q)
			ST_CLEAR: begin
				acc_we    = 1'b1;
				acc_waddr = clr_q;
			end
			ST_IDLE: begin
				if (cmd_pop) begin
					case (cmd_in.op)
						CMD_LOAD: sc_we = 1'b1;
						CMD_READ: acc_re = 1'b1;
						CMD_ACC: begin
							if (cmd_in.ncols != 3'd0) begin
								acc_re    = 1'b1;
								sc_re     = 1'b1;
								acc_raddr = acc_addr(cmd_in.set_index, 3'd0);
							end
						end
						default: ;
					endcase
				end
			end
			ST_READ: ;
			ST_ACC: begin
				acc_we = 1'b1;
				if (!last_col) begin
					acc_re    = 1'b1;
					sc_re     = 1'b1;
					acc_raddr = acc_addr(cmd_q.set_index, col_nx);
					sc_raddr  = sc_addr(cmd_q.gene_index, col_nx);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (acc_we) acc_mem[acc_waddr] <= clearing ? 48'd0 : acc_wdata;
		if (acc_re) acc_rdata_q <= acc_mem[acc_raddr];
	end

	always_ff @(posedge clk) begin
		if (sc_we) sc_mem[sc_waddr] <= cmd_in.score;
		if (sc_re) sc_rdata_q <= sc_mem[sc_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			col_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop && out_valid_q) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ACC_AW'(ACC_DEPTH - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (cmd_pop) begin
						col_q <= '0;
						case (cmd_in.op)
							CMD_READ: state_q <= ST_READ;
							CMD_ACC: begin
								if (cmd_in.ncols != 3'd0) state_q <= ST_ACC;
								else out_valid_q <= 1'b1;
							end
							default: out_valid_q <= 1'b1;
						endcase
					end
				end
				ST_READ: begin
					out_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				ST_ACC: begin
					if (last_col) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end else begin
						col_q <= col_nx;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// held command and result payload
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q        <= cmd_in;
			out_q.status <= cmd_in.op == CMD_FLAG;
			out_q.value  <= '0;
		end
		if (state_q == ST_READ) out_q.value <= acc_rdata_q;
	end

endmodule

`default_nettype wire

@@ tb/tb_set_score_scatter_accumulator_core.sv @@
// Self-checking testbench for set_score_scatter_accumulator_core.
// Depends on sscc_pkg and the block's RTL; drives requests, register writes and
// back-pressure; each result is checked against a predicted or hand-set value.
`default_nettype none

module tb_set_score_scatter_accumulator_core;
	import sscc_pkg::*;

	localparam int CLK_PERIOD     = 10;
	localparam int TIMEOUT_CYCLES = 3_000_000;
	localparam int N_SETS         = 1024;
	localparam int N_GENES        = 4096;
	localparam int N_COLS         = 4;
	localparam int RANDOM_PHASES  = 7;
	localparam int PHASE_ITEMS    = 90;
	localparam int BURST_REPEATS  = 40;
	localparam int HOLD_CYCLES    = 250;
	localparam int IDLE_PERCENT   = 34;
	localparam int DRAIN_CYCLES   = 20;

	// func code the block does not define; must come back flagged
	localparam logic [1:0]        FUNC_NONE  = 2'd3;
	// register index with no register behind it
	localparam logic [CFG_IW-1:0] CFG_UNUSED = 2'd3;

	localparam logic        STATUS_OK   = 1'b0;
	localparam logic        STATUS_FLAG = 1'b1;
	localparam logic [47:0] ACC_TOP     = 48'h7FFF_FFFF_FFFF;
	localparam logic [47:0] ACC_BOTTOM  = 48'h8000_0000_0000;

	// one row of the directed list: either a register write or a request,
	// the latter optionally with its result written out by hand
	typedef struct packed {
		bit                is_cfg;
		logic [CFG_IW-1:0] cfg_idx;
		logic [CFG_DW-1:0] cfg_val;
		sscc_req_t         req;
		bit                typed;
		sscc_rsp_t         want;
	} step_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              push;
	logic              full;
	sscc_req_t         req;
	logic              empty;
	logic              pop;
	sscc_rsp_t         result;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [CFG_IW-1:0] cfg_index;
	logic [CFG_DW-1:0] cfg_data;

	set_score_scatter_accumulator_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.req       (req),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor state: own copy of both stores and the three registers.
	// score_loaded tracks which score entries have been written, so that the
	// stimulus never accumulates an undefined score.
	// ------------------------------------------------------------------
	bit   [31:0] gene_scores  [N_GENES * N_COLS];
	bit          score_loaded [N_GENES * N_COLS];
	bit   [47:0] set_sums     [N_SETS * N_COLS];
	logic [10:0] reg_sets  = SETS_RST;
	logic [12:0] reg_genes = GENES_RST;
	logic [2:0]  reg_cols  = COLS_RST;

	sscc_rsp_t   awaited_results [$];
	logic [9:0]  hot_sets  [8];
	logic [11:0] hot_genes [8];

	bit          calm;          // no idling on either side while set
	int unsigned hold_asks;     // bumped by the stimulus to ask for a long pop hold-off
	int unsigned holds_done;
	int unsigned mismatches;
	int unsigned results_seen;
	int unsigned n_requests;
	int unsigned n_flagged;
	int unsigned n_writes;
	int unsigned sat_hits;
	int unsigned full_stalls;

	// limits in force: register value, capped at the build size
	function automatic int unsigned limit_sets();
		return (reg_sets > N_SETS) ? N_SETS : reg_sets;
	endfunction

	function automatic int unsigned limit_genes();
		return (reg_genes > N_GENES) ? N_GENES : reg_genes;
	endfunction

	function automatic int unsigned limit_cols();
		return (reg_cols > N_COLS) ? N_COLS : reg_cols;
	endfunction

	function automatic void apply_register(input logic [CFG_IW-1:0] idx,
			input logic [CFG_DW-1:0] val);
		case (idx)
			CFG_SETS:  reg_sets  = val[10:0];
			CFG_GENES: reg_genes = val[12:0];
			CFG_COLS:  reg_cols  = val[2:0];
			default: ;
		endcase
	endfunction

	// Works out the result of one request and updates the stores to match.
	function automatic sscc_rsp_t predict_outcome(input sscc_req_t r);
		sscc_rsp_t   o;
		logic [48:0] sum;
		int unsigned set_row;
		int unsigned gene_row;
		o.status = STATUS_OK;
		o.value  = '0;
		set_row  = r.set_index * N_COLS;
		gene_row = r.gene_index * N_COLS;
		case (r.func)
			FUNC_LOAD: begin
				if (r.gene_index < limit_genes() && r.column < limit_cols()) begin
					gene_scores[gene_row + r.column]  = r.score_value;
					score_loaded[gene_row + r.column] = 1'b1;
				end else begin
					o.status = STATUS_FLAG;
				end
			end
			FUNC_ACC: begin
				if (r.set_index < limit_sets() && r.gene_index < limit_genes()) begin
					for (int c = 0; c < int'(limit_cols()); c++) begin
						// 49-bit sum of sign-extended operands; top two bits show overflow
						sum = {set_sums[set_row + c][47], set_sums[set_row + c]}
							+ {{17{gene_scores[gene_row + c][31]}}, gene_scores[gene_row + c]};
						case (sum[48:47])
							2'b01: begin
								set_sums[set_row + c] = ACC_TOP;
								sat_hits++;
							end
							2'b10: begin
								set_sums[set_row + c] = ACC_BOTTOM;
								sat_hits++;
							end
							default: set_sums[set_row + c] = sum[47:0];
						endcase
					end
				end else begin
					o.status = STATUS_FLAG;
				end
			end
			FUNC_READ: begin
				if (r.set_index < limit_sets() && r.column < limit_cols())
					o.value = set_sums[set_row + r.column];
				else
					o.status = STATUS_FLAG;
			end
			default: o.status = STATUS_FLAG;
		endcase
		return o;
	endfunction

	// Random request, mostly on a small pool of hot rows so that loads,
	// accumulates and reads keep meeting. An in-range pair whose gene lacks a
	// score in some column in use turns into the load of that column.
	function automatic sscc_req_t next_random_request();
		sscc_req_t   r;
		int unsigned roll;
		int          top;
		r.set_index  = ($urandom_range(9) < 8) ? hot_sets[$urandom_range(7)] : 10'($urandom);
		r.gene_index = ($urandom_range(9) < 8) ? hot_genes[$urandom_range(7)] : 12'($urandom);
		r.column     = 2'($urandom);
		case ($urandom_range(9))
			0:       r.score_value = 32'h7FFF_FFFF;
			1:       r.score_value = 32'h8000_0000;
			default: r.score_value = $urandom;
		endcase
		roll = $urandom_range(99);
		if (roll < 4) begin
			r.func = FUNC_NONE;
		end else if (roll < 34) begin
			r.func = FUNC_LOAD;
		end else if (roll < 70) begin
			r.func = FUNC_ACC;
			if (r.set_index < limit_sets() && r.gene_index < limit_genes()) begin
				top = int'(limit_cols()) - 1;
				for (int c = top; c >= 0; c--)
					if (!score_loaded[r.gene_index * N_COLS + c]) begin
						r.func   = FUNC_LOAD;
						r.column = 2'(c);
					end
			end
		end else begin
			r.func = FUNC_READ;
		end
		return r;
	endfunction

	// directed-list row builders
	function automatic step_t rq(input logic [1:0] f, input int unsigned s,
			input int unsigned g, input int unsigned c, input logic [31:0] v);
		step_t t;
		t                 = '0;
		t.req.func        = f;
		t.req.set_index   = 10'(s);
		t.req.gene_index  = 12'(g);
		t.req.column      = 2'(c);
		t.req.score_value = v;
		return t;
	endfunction

	function automatic step_t rqx(input logic [1:0] f, input int unsigned s,
			input int unsigned g, input int unsigned c, input logic [31:0] v,
			input logic st, input logic [47:0] val);
		step_t t;
		t             = rq(f, s, g, c, v);
		t.typed       = 1'b1;
		t.want.status = st;
		t.want.value  = val;
		return t;
	endfunction

	function automatic step_t cf(input logic [CFG_IW-1:0] idx, input int unsigned val);
		step_t t;
		t         = '0;
		t.is_cfg  = 1'b1;
		t.cfg_idx = idx;
		t.cfg_val = CFG_DW'(val);
		return t;
	endfunction

	// ------------------------------------------------------------------
	// Request side. Each call starts at a falling edge and returns at the
	// rising edge that took the request, push still high; whatever comes
	// next sets push exactly once at the following falling edge.
	// ------------------------------------------------------------------
	task automatic send_request(input sscc_req_t r, input bit typed, input sscc_rsp_t want);
		sscc_rsp_t predicted;
		@(negedge clk);
		while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		req  <= r;
		do @(posedge clk); while (full !== 1'b0);
		predicted = predict_outcome(r);
		n_requests++;
		if (predicted.status == STATUS_FLAG)
			n_flagged++;
		awaited_results.push_back(typed ? want : predicted);
	endtask

	// Register writes only with the block idle: push dropped, every result in.
	task automatic write_register(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
		@(negedge clk);
		push <= 1'b0;
		while (awaited_results.size() != 0)
			@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		apply_register(idx, val);
		n_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Result side: random pop idling, plus the long hold-off on request,
	// which lets the queue behind the block fill and push back via full.
	// ------------------------------------------------------------------
	initial begin
		pop = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_asks != holds_done) begin
				holds_done++;
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			pop <= calm || ($urandom_range(99) >= IDLE_PERCENT);
		end
	end

	// Result checker: oldest expectation against each popped result.
	always @(posedge clk) begin
		sscc_rsp_t exp_rsp;
		if (arst_n && pop && empty === 1'b0) begin
			if (awaited_results.size() == 0) begin
				$error("result popped with no request awaiting it: status %0d value %h",
					result.status, result.value);
				mismatches++;
			end else begin
				exp_rsp = awaited_results.pop_front();
				results_seen++;
				if (result.status !== exp_rsp.status) begin
					$error("status: expected %0d, got %0d", exp_rsp.status, result.status);
					mismatches++;
				end
				if (result.value !== exp_rsp.value) begin
					$error("value: expected %h, got %h", exp_rsp.value, result.value);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk)
		if (push && full)
			full_stalls++;

	// Overall time limit
	initial begin
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("tb_set_score_scatter_accumulator_core NOT OK");
		$finish;
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		step_t             directed_steps [$];
		logic [CFG_DW-1:0] plan_sets;
		logic [CFG_DW-1:0] plan_genes;
		logic [CFG_DW-1:0] plan_cols;
		sscc_req_t         burst_req;

		arst_n    = 1'b0;
		push      = 1'b0;
		req       = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_SETS;
		cfg_data  = '0;
		calm      = 1'b0;

		directed_steps = '{
			// fresh from reset: every sum reads zero, limits 1024/4096/1
			rqx(FUNC_READ, 0, 0, 0, 0, STATUS_OK, 48'h0),
			rqx(FUNC_READ, 1023, 0, 0, 0, STATUS_OK, 48'h0),
			// column beyond the one in use; undefined func with all-ones fields
			rqx(FUNC_READ, 0, 0, 1, 0, STATUS_FLAG, 48'h0),
			rqx(FUNC_NONE, 1023, 4095, 3, 32'hFFFF_FFFF, STATUS_FLAG, 48'h0),
			// extreme scores into the corner genes, then into corner sets
			rqx(FUNC_LOAD, 0, 0, 0, 32'h7FFF_FFFF, STATUS_OK, 48'h0),
			rqx(FUNC_LOAD, 1023, 4095, 0, 32'h8000_0000, STATUS_OK, 48'h0),
			rqx(FUNC_LOAD, 0, 0, 1, 32'h1, STATUS_FLAG, 48'h0),
			rqx(FUNC_ACC, 0, 0, 0, 0, STATUS_OK, 48'h0),
			rqx(FUNC_ACC, 1023, 4095, 3, 0, STATUS_OK, 48'h0),
			rqx(FUNC_READ, 0, 0, 0, 0, STATUS_OK, 48'h0000_7FFF_FFFF),
			rqx(FUNC_READ, 1023, 0, 0, 0, STATUS_OK, 48'hFFFF_8000_0000),
			rqx(FUNC_ACC, 0, 4095, 0, 0, STATUS_OK, 48'h0),
			rqx(FUNC_READ, 0, 0, 0, 0, STATUS_OK, 48'hFFFF_FFFF_FFFF),
			// all four columns per pair
			cf(CFG_COLS, 4),
			rq(FUNC_LOAD, 0, 5, 0, 32'h0001_0000),
			rq(FUNC_LOAD, 0, 5, 1, 32'hFFFF_0000),
			rq(FUNC_LOAD, 0, 5, 2, 32'h1234_5678),
			rq(FUNC_LOAD, 0, 5, 3, 32'hEDCB_A988),
			rq(FUNC_ACC, 7, 5, 0, 0),
			rq(FUNC_ACC, 7, 5, 0, 0),
			rq(FUNC_READ, 7, 0, 3, 0),
			rq(FUNC_READ, 7, 0, 2, 0),
			// a single set and a single gene
			cf(CFG_SETS, 1),
			cf(CFG_GENES, 1),
			rqx(FUNC_ACC, 1, 0, 0, 0, STATUS_FLAG, 48'h0),
			rqx(FUNC_LOAD, 0, 1, 0, 32'h5, STATUS_FLAG, 48'h0),
			rqx(FUNC_READ, 0, 0, 0, 0, STATUS_OK, 48'hFFFF_FFFF_FFFF),
			cf(CFG_UNUSED, 13'h1FFF),
			// zero limits flag every index compared with them
			cf(CFG_SETS, 0),
			rqx(FUNC_READ, 0, 0, 0, 0, STATUS_FLAG, 48'h0),
			cf(CFG_GENES, 0),
			rqx(FUNC_LOAD, 0, 0, 0, 32'h1, STATUS_FLAG, 48'h0),
			cf(CFG_COLS, 0),
			rqx(FUNC_ACC, 0, 0, 0, 0, STATUS_FLAG, 48'h0)
		};

		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_steps[i]) begin
			if (directed_steps[i].is_cfg)
				write_register(directed_steps[i].cfg_idx, directed_steps[i].cfg_val);
			else
				send_request(directed_steps[i].req, directed_steps[i].typed,
					directed_steps[i].want);
		end

		// Burst run flat out with no idling on either side: one gene holding
		// the largest score in column 0 and the most negative in column 1,
		// added again and again into an untouched set.
		calm = 1'b1;
		write_register(CFG_SETS, 13'd1024);
		write_register(CFG_GENES, 13'd4096);
		write_register(CFG_COLS, 13'd2);
		send_request(rq(FUNC_LOAD, 0, 4095, 0, 32'h7FFF_FFFF).req, 1'b0, '0);
		send_request(rq(FUNC_LOAD, 0, 4095, 1, 32'h8000_0000).req, 1'b0, '0);
		burst_req = rq(FUNC_ACC, 1022, 4095, 0, 0).req;
		repeat (BURST_REPEATS) send_request(burst_req, 1'b0, '0);
		send_request(rq(FUNC_READ, 1022, 0, 0, 0).req, 1'b0, '0);
		send_request(rq(FUNC_READ, 1022, 0, 1, 0).req, 1'b0, '0);
		// step back towards zero
		send_request(rq(FUNC_LOAD, 0, 4095, 0, 32'hFFFF_FFFF).req, 1'b0, '0);
		send_request(rq(FUNC_LOAD, 0, 4095, 1, 32'h0000_0001).req, 1'b0, '0);
		send_request(burst_req, 1'b0, '0);
		send_request(rq(FUNC_READ, 1022, 0, 0, 0).req, 1'b0, '0);
		send_request(rq(FUNC_READ, 1022, 0, 1, 0).req, 1'b0, '0);
		calm = 1'b0;

		// Random phases, each under its own register setting: full size,
		// minimum, above the caps, no genes, then random sizes.
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: begin
					plan_sets  = 13'd1024;
					plan_genes = 13'd4096;
					plan_cols  = 13'd4;
				end
				1: begin
					plan_sets  = 13'd1;
					plan_genes = 13'd1;
					plan_cols  = 13'd1;
				end
				2: begin
					plan_sets  = 13'd2047;
					plan_genes = 13'd8191;
					plan_cols  = 13'd7;
				end
				3: begin
					plan_sets  = CFG_DW'($urandom_range(1, 1024));
					plan_genes = 13'd0;
					plan_cols  = 13'd4;
				end
				default: begin
					plan_sets  = CFG_DW'($urandom_range(1) ? $urandom_range(1, 16)
						: $urandom_range(1, 1024));
					plan_genes = CFG_DW'($urandom_range(1) ? $urandom_range(1, 32)
						: $urandom_range(1, 4096));
					plan_cols  = CFG_DW'($urandom_range(1, 4));
				end
			endcase
			write_register(CFG_SETS, plan_sets);
			write_register(CFG_GENES, plan_genes);
			write_register(CFG_COLS, plan_cols);

			// hot rows: first, last and the rest random in range; any at a zero limit
			for (int i = 0; i < 8; i++) begin
				hot_sets[i] = (limit_sets() == 0) ? 10'($urandom)
					: (i == 0) ? 10'd0
					: (i == 1) ? 10'(limit_sets() - 1)
					: 10'($urandom_range(limit_sets() - 1));
				hot_genes[i] = (limit_genes() == 0) ? 12'($urandom)
					: (i == 0) ? 12'd0
					: (i == 1) ? 12'(limit_genes() - 1)
					: 12'($urandom_range(limit_genes() - 1));
			end

			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (phase == 0 && i == 30)
					hold_asks++;
				send_request(next_random_request(), 1'b0, '0);
			end
		end

		@(negedge clk);
		push <= 1'b0;
		while (awaited_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d requests (%0d flagged) across %0d register writes: zero, one, full and over-cap limits.",
			n_requests, n_flagged, n_writes);
		$display("%0d results checked; %0d sums clipped at a bound; push held off by full on %0d cycles.",
			results_seen, sat_hits, full_stalls);
		if (mismatches == 0)
			$display("tb_set_score_scatter_accumulator_core OK");
		else
			$display("tb_set_score_scatter_accumulator_core NOT OK");
		$finish;
	end

endmodule

`default_nettype wire

@@ files.f @@
hdl/sscc_pkg.sv
hdl/sscc_front.sv
hdl/sscc_cmd_queue.sv
hdl/sscc_back.sv
hdl/set_score_scatter_accumulator_core.sv
tb/tb_set_score_scatter_accumulator_core.sv
